// File: design/png_pkg.sv
// ----------------------------------------------------------------------------
// png_pkg
// shared types and constants of the pink noise generator
// ----------------------------------------------------------------------------
package png_pkg;

   localparam int INDEX_W  = 6;
   localparam int SAMPLE_W = 16;
   localparam int BYTE_W   = 8;

   localparam logic FUNC_GENERATE = 1'b0;
   localparam logic FUNC_WRITE    = 1'b1;

   localparam logic SEL_UPPER = 1'b0;
   localparam logic SEL_LOWER = 1'b1;

   localparam logic [31:0] LFSR_SEED   = 32'h5EED41F5;
   localparam logic [31:0] LFSR_TAPS   = 32'h46000001;
   localparam logic [15:0] OCTAVE_INIT = 16'h0CCC;
   localparam logic [15:0] COUNT_INIT  = 16'h0AAA;
   localparam logic [BYTE_W-1:0] HELD_INIT  = 8'h80;
   localparam logic [BYTE_W-1:0] PWM_OFFSET = 8'h80;

   // table indexes taken from the twelve low bits of the next lfsr word
   typedef struct packed {
      logic [INDEX_W-1:0] upper_idx;
      logic [INDEX_W-1:0] lower_idx;
   } png_draw_type;

endpackage

// File: design/pink_noise_generator.sv
// ----------------------------------------------------------------------------
// pink_noise_generator
// twelve-octave pink noise source with fir correction and 8-bit error feedback
// ----------------------------------------------------------------------------
// a generate item goes through the table read register and the result register
// throughput: one item per cycle unless a result waits on rsp_tready;
// table reads sit behind one registered port; a table write item gives no result
// reset clears the noise state, the quantizer and both channels; the fir
// tables are not cleared and must be written before use
module pink_noise_generator #(
   parameter int FIR_TABLE_DEPTH = 64,
   parameter int OCTAVES         = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // table_index[5:0], table_value[21:6], zero[23:22]
   input  logic [1:0]  req_tuser,  // func[0], table_select[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // pwm_level[7:0], raw_sample[23:8]
);
   import png_pkg::*;

   localparam int ADDR_W = $clog2(FIR_TABLE_DEPTH);

   logic                gen_acc;
   logic                wr_acc;
   logic                s1_advance;
   png_draw_type        draw_next;
   logic [SAMPLE_W-1:0] running_sum;
   logic [INDEX_W-1:0]  wr_idx;
   logic                wr_ok;
   logic                upper_ok, lower_ok;

   logic [SAMPLE_W-1:0] upper_fir_ff [FIR_TABLE_DEPTH];
   logic [SAMPLE_W-1:0] lower_fir_ff [FIR_TABLE_DEPTH];
   logic [SAMPLE_W-1:0] upper_rd_ff, lower_rd_ff;
   logic                upper_ok_ff, lower_ok_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   held_byte_ff, held_byte_in;
   logic [BYTE_W-1:0]   carry_error_ff, carry_error_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;
   logic [SAMPLE_W-1:0] sum;
   logic [SAMPLE_W-1:0] quant;

   assign req_tready = !s1_valid_ff || !rsp_valid_ff || rsp_tready;
   assign gen_acc    = req_tvalid && req_tready && (req_tuser[0] == FUNC_GENERATE);
   assign wr_acc     = req_tvalid && req_tready && (req_tuser[0] == FUNC_WRITE);
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign wr_idx   = req_tdata[5:0];
   assign wr_ok    = 32'(wr_idx) < FIR_TABLE_DEPTH;
   assign upper_ok = 32'(draw_next.upper_idx) < FIR_TABLE_DEPTH;
   assign lower_ok = 32'(draw_next.lower_idx) < FIR_TABLE_DEPTH;

   png_octave_core #(
      .OCTAVES(OCTAVES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (gen_acc),
      .draw_next  (draw_next),
      .running_sum(running_sum)
   );

   // fir tables
   always_ff @(posedge clock) begin
      if (wr_acc && wr_ok) begin
         if (req_tuser[1] == SEL_LOWER) begin
            lower_fir_ff[ADDR_W'(wr_idx)] <= req_tdata[21:6];
         end else begin
            upper_fir_ff[ADDR_W'(wr_idx)] <= req_tdata[21:6];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen_acc) begin
         upper_rd_ff <= upper_fir_ff[ADDR_W'(draw_next.upper_idx)];
         lower_rd_ff <= lower_fir_ff[ADDR_W'(draw_next.lower_idx)];
         upper_ok_ff <= upper_ok;
         lower_ok_ff <= lower_ok;
      end
   end

   // sum and quantizer
   always_comb begin
      sum = running_sum + (upper_ok_ff ? upper_rd_ff : '0) + (lower_ok_ff ? lower_rd_ff : '0);
      quant = sum + SAMPLE_W'(carry_error_ff);

      s1_valid_in    = s1_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      held_byte_in   = held_byte_ff;
      carry_error_in = carry_error_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         s1_valid_in    = 1'b0;
         rsp_valid_in   = 1'b1;
         held_byte_in   = quant[15:8];
         carry_error_in = quant[7:0];
         rsp_data_in    = {sum, held_byte_ff + PWM_OFFSET};
      end
      if (gen_acc) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         held_byte_ff   <= HELD_INIT;
         carry_error_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_byte_ff   <= held_byte_in;
         carry_error_ff <= carry_error_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/png_octave_core.sv
// ----------------------------------------------------------------------------
// png_octave_core
// lfsr, octave counter, rise/fall words and running sum of the noise source
// ----------------------------------------------------------------------------
module png_octave_core #(
   parameter int OCTAVES = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   output png_pkg::png_draw_type draw_next,
   output logic [15:0]          running_sum
);
   import png_pkg::*;

   logic [31:0]         noise_shift_ff, noise_shift_in;
   logic [OCTAVES-1:0]  octave_count_ff, octave_count_in;
   logic [OCTAVES-1:0]  rise_bits_ff, rise_bits_in;
   logic [OCTAVES-1:0]  fall_bits_ff, fall_bits_in;
   logic [SAMPLE_W-1:0] running_sum_ff, running_sum_in;
   logic [OCTAVES-1:0]  lowest_bit;
   logic [OCTAVES-1:0]  sel;
   logic [OCTAVES-1:0]  rnd;

   always_comb begin
      rnd            = {OCTAVES{noise_shift_ff[31]}};
      noise_shift_in = {noise_shift_ff[30:0], 1'b0} ^ (noise_shift_ff[31] ? LFSR_TAPS : '0);
      octave_count_in = octave_count_ff + OCTAVES'(1);
      lowest_bit      = octave_count_in & (~octave_count_in + OCTAVES'(1));
      for (int i = 0; i < OCTAVES; i++) begin
         sel[i] = lowest_bit[OCTAVES-1-i];
      end
      fall_bits_in   = (fall_bits_ff & ~sel) | (rise_bits_ff & sel);
      rise_bits_in   = rise_bits_ff ^ (rnd & sel);
      running_sum_in = running_sum_ff + SAMPLE_W'(rise_bits_in) - SAMPLE_W'(fall_bits_in);
   end

   assign draw_next.upper_idx = noise_shift_in[11:6];
   assign draw_next.lower_idx = noise_shift_in[5:0];
   assign running_sum         = running_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_shift_ff  <= LFSR_SEED;
         octave_count_ff <= OCTAVES'(COUNT_INIT);
         rise_bits_ff    <= OCTAVES'(OCTAVE_INIT);
         fall_bits_ff    <= OCTAVES'(OCTAVE_INIT);
         running_sum_ff  <= '0;
      end else if (step) begin
         noise_shift_ff  <= noise_shift_in;
         octave_count_ff <= octave_count_in;
         rise_bits_ff    <= rise_bits_in;
         fall_bits_ff    <= fall_bits_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

// File: design/png_checker.sv
// ----------------------------------------------------------------------------
// png_checker
// port-level checks of the pink noise generator
// ----------------------------------------------------------------------------
module png_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import png_pkg::*;

   logic gen_acc;

   assign gen_acc = req_tvalid && req_tready && (req_tuser[0] == FUNC_GENERATE);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a waiting result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // an empty output never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a result on an empty output needs a generate item in the read stage
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(gen_acc) |=> !rsp_tvalid)
      else $error("result without a generate item");

endmodule

bind pink_noise_generator png_checker u_png_checker (.*);

// File: tb/pink_noise_generator_test.sv
// ----------------------------------------------------------------------------
// pink_noise_generator_test
// Self-checking bench for the pink noise generator. Both fir tables are
// preloaded first, so no generate item ever reads an entry that was never
// written. A short table of directed items follows, then a random mix
// of generate and write items. Every generate result is checked against a
// cycle-free model of the noise state kept in the bench. Both channels idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module pink_noise_generator_test;
   import png_pkg::*;

   localparam int TAB_DEPTH    = 1 << INDEX_W;
   localparam int PRELOAD      = 2 * TAB_DEPTH;
   localparam int DIRECT_ROWS  = 20;
   localparam int RANDOM_ITEMS = 602;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic                func;
      logic                sel;
      logic [INDEX_W-1:0]  idx;
      logic [SAMPLE_W-1:0] value;
      logic                pwm_known;
      logic [BYTE_W-1:0]   pwm;
   } stim_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   pwm;
      logic [SAMPLE_W-1:0] raw;
   } noise_result_type;

   typedef struct packed {
      logic              known;
      logic [BYTE_W-1:0] pwm;
   } pwm_hint_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // table_index[5:0], table_value[21:6], zero[23:22]
   logic [1:0]  req_tuser;   // func[0], table_select[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // pwm_level[7:0], raw_sample[23:8]

   // model of the noise state
   logic [31:0]         lfsr_q;
   logic [11:0]         rise_q;
   logic [11:0]         fall_q;
   logic [11:0]         count_q;
   logic [15:0]         acc_q;
   logic [BYTE_W-1:0]   held_q;
   logic [BYTE_W-1:0]   err_q;
   logic [SAMPLE_W-1:0] upper_tab [TAB_DEPTH];
   logic [SAMPLE_W-1:0] lower_tab [TAB_DEPTH];

   noise_result_type expected_samples [$];
   pwm_hint_type     pwm_hints [$];
   noise_result_type oldest;

   int error_count = 0;
   int items_sent  = 0;
   int gens_sent   = 0;
   int taken       = 0;
   int rsp_gap;
   bit held_off    = 1'b0;

   logic                rnd_func;
   logic [SAMPLE_W-1:0] rnd_value;

   stim_row_type directed_rows [DIRECT_ROWS] = '{
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b1, 8'h00},  // held 0x80 after reset
      '{FUNC_GENERATE, SEL_LOWER, 6'd63, 16'hFFFF, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_UPPER, 6'd0,  16'h8000, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_UPPER, 6'd63, 16'h7FFF, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_LOWER, 6'd0,  16'hFFFF, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_LOWER, 6'd63, 16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_UPPER, 6'h2A, 16'h5555, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_LOWER, 6'h15, 16'hAAAA, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_LOWER, 6'h2A, 16'h5555, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_UPPER, 6'h15, 16'h8000, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_LOWER, 6'h2A, 16'h7FFF, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00},
      '{FUNC_WRITE,    SEL_LOWER, 6'd1,  16'h0001, 1'b0, 8'h00},
      '{FUNC_GENERATE, SEL_UPPER, 6'd0,  16'h0000, 1'b0, 8'h00}
   };

   pink_noise_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string text);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", text);
      end
   endtask

   task automatic predict_noise_item(input logic [1:0] user, input logic [23:0] data);
      logic [11:0]      rnd;
      logic [11:0]      low_bit;
      logic [11:0]      sel;
      logic [15:0]      q;
      png_draw_type     draw;
      noise_result_type res;
      pwm_hint_type     hint;
      int               i;
      if (user[0] == FUNC_WRITE) begin
         if (user[1] == SEL_LOWER) begin
            lower_tab[data[5:0]] = data[21:6];
         end else begin
            upper_tab[data[5:0]] = data[21:6];
         end
      end else begin
         res.pwm = held_q + PWM_OFFSET;
         rnd = lfsr_q[31] ? 12'hFFF : 12'h000;
         lfsr_q = lfsr_q << 1;
         if (rnd != 12'h000) begin
            lfsr_q = lfsr_q ^ LFSR_TAPS;
         end
         count_q = count_q + 12'd1;
         // lowest set bit, bit-reversed; zero when the counter wraps
         low_bit = count_q & (~count_q + 12'd1);
         for (i = 0; i < 12; i++) begin
            sel[i] = low_bit[11 - i];
         end
         fall_q = (fall_q & ~sel) | (rise_q & sel);
         rise_q = rise_q ^ (rnd & sel);
         acc_q = acc_q + {4'h0, rise_q} - {4'h0, fall_q};
         draw = lfsr_q[11:0];
         res.raw = acc_q + upper_tab[draw.upper_idx] + lower_tab[draw.lower_idx];
         q = res.raw + {8'h00, err_q};
         held_q = q[15:8];
         err_q = q[7:0];
         hint = pwm_hints.pop_front();
         if (hint.known) begin
            res.pwm = hint.pwm;
         end
         expected_samples.push_back(res);
      end
   endtask

   task automatic send_item(input logic func, input logic sel,
                            input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] value,
                            input logic pwm_known, input logic [BYTE_W-1:0] pwm);
      int gap;
      gap = (items_sent % 64 < 16) ? 0 : $urandom_range(0, 9);
      if (func == FUNC_GENERATE) begin
         pwm_hints.push_back('{pwm_known, pwm});
         gens_sent++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {sel, func};
      req_tdata  <= {2'b00, value, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_noise_item(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report($sformatf("unexpected item pwm=%h raw=%h",
                                rsp_tdata[7:0], rsp_tdata[23:8]));
            end else begin
               oldest = expected_samples.pop_front();
               if (rsp_tdata[7:0] !== oldest.pwm) begin
                  report($sformatf("pwm_level expected %h got %h",
                                   oldest.pwm, rsp_tdata[7:0]));
               end
               if (rsp_tdata[23:8] !== oldest.raw) begin
                  report($sformatf("raw_sample expected %h got %h",
                                   oldest.raw, rsp_tdata[23:8]));
               end
            end
         end
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_gap  = HOLD_CYCLES;
         end else if (taken % 64 < 12) begin
            rsp_gap = 0;
         end else begin
            rsp_gap = $urandom_range(0, 9);
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      lfsr_q  = LFSR_SEED;
      rise_q  = OCTAVE_INIT[11:0];
      fall_q  = OCTAVE_INIT[11:0];
      count_q = COUNT_INIT[11:0];
      acc_q   = 16'h0000;
      held_q  = HELD_INIT;
      err_q   = 8'h00;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 24'h000000;
      req_tuser  <= 2'b00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // near-full entries push the quantizer past its wrap point
      for (int t = 0; t < 2; t++) begin
         for (int i = 0; i < TAB_DEPTH; i++) begin
            send_item(FUNC_WRITE, t[0], i[INDEX_W-1:0], 16'h7FFF, 1'b0, 8'h00);
         end
      end

      for (int r = 0; r < DIRECT_ROWS; r++) begin
         send_item(directed_rows[r].func, directed_rows[r].sel, directed_rows[r].idx,
                   directed_rows[r].value, directed_rows[r].pwm_known, directed_rows[r].pwm);
      end

      // random mix of generate and write items
      while (items_sent < PRELOAD + DIRECT_ROWS + RANDOM_ITEMS) begin
         rnd_func = ($urandom_range(0, 99) < 85) ? FUNC_GENERATE : FUNC_WRITE;
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: rnd_value = 16'h8000;
               1: rnd_value = 16'h7FFF;
               2: rnd_value = 16'h0000;
               default: rnd_value = 16'hFFFF;
            endcase
         end else begin
            rnd_value = SAMPLE_W'($urandom);
         end
         send_item(rnd_func, 1'($urandom_range(0, 1)),
                   INDEX_W'($urandom_range(0, TAB_DEPTH - 1)), rnd_value, 1'b0, 8'h00);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (expected_samples.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
